// ===== src/bbpt_pkg.sv =====
// ----------------------------------------------------------------------------
// bbpt_pkg
// Shared types and constants of the biquadratic Bezier patch tessellator.
// ----------------------------------------------------------------------------
`default_nettype none

package bbpt_pkg;

  localparam int unsigned MAX_LEVEL    = 16;
  localparam int unsigned LEVEL_W      = 5;
  localparam int unsigned NUM_PTS      = 9;
  localparam int unsigned NUM_CRD      = 7;
  localparam int unsigned CRD_W        = 32;
  localparam int unsigned SLOT_W       = 4;
  localparam int unsigned GRID_W       = 5;
  localparam int unsigned VNUM_W       = 9;
  localparam int unsigned S_TDATA_W    = 240;
  localparam int unsigned M_TDATA_W    = 240;
  localparam int unsigned S_TUSER_W    = 2;
  localparam int unsigned M_TUSER_W    = 2;
  localparam int unsigned WGT_W        = 17;
  localparam int unsigned NUM_W        = 21;
  localparam int unsigned RECIP_W      = 28;
  localparam int unsigned RECIP_SHIFT  = 27;
  localparam int unsigned PROD_W       = 49;
  localparam int unsigned SUM_W        = 51;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 5'd8;
  localparam logic [2:0]         TRI_LAST    = 3'd5;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_EVAL = 2'd1,
    OP_TRI  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  // Per-request control that travels beside the datapath.
  typedef struct packed {
    op_e               op;
    logic              err;
    logic [VNUM_W-1:0] base;
    logic [LEVEL_W-1:0] width;
  } meta_t;

  // ceil(2^27 / level): exact quotient for numerators below 2^21.
  function automatic logic [RECIP_W-1:0] recip(input logic [LEVEL_W-1:0] lvl);
    logic [RECIP_W-1:0] r;
    case (lvl)
      5'd1:    r = 28'd134217728;
      5'd2:    r = 28'd67108864;
      5'd3:    r = 28'd44739243;
      5'd4:    r = 28'd33554432;
      5'd5:    r = 28'd26843546;
      5'd6:    r = 28'd22369622;
      5'd7:    r = 28'd19173962;
      5'd8:    r = 28'd16777216;
      5'd9:    r = 28'd14913081;
      5'd10:   r = 28'd13421773;
      5'd11:   r = 28'd12201612;
      5'd12:   r = 28'd11184811;
      5'd13:   r = 28'd10324441;
      5'd14:   r = 28'd9586981;
      5'd15:   r = 28'd8947849;
      5'd16:   r = 28'd8388608;
      default: r = 28'd134217728;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/biquadratic_bezier_patch_tessellator.sv =====
// ----------------------------------------------------------------------------
// biquadratic_bezier_patch_tessellator
// Loads, evaluations and ignored requests flow at one per cycle while the
// result side keeps up; an in-range triangulate request holds the output
// register until it has handed over its six vertex numbers, and the
// pipeline behind it stalls meanwhile. Reset clears all valid bits and
// sets the level to 8; the control grid is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module biquadratic_bezier_patch_tessellator (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Level register write port.
  input  wire logic                           cfg_we_i,
  input  wire logic [bbpt_pkg::LEVEL_W-1:0]   cfg_wdata_i,
  // Request channel.
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata: point_slot[3:0], grid_row[8:4], grid_col[13:9], pos_x[45:14],
  // pos_y[77:46], pos_z[109:78], tex_u[141:110], tex_v[173:142],
  // light_u[205:174], light_v[237:206], zero pad[239:238].
  input  wire logic [bbpt_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // tuser: op[1:0].
  input  wire logic [bbpt_pkg::S_TUSER_W-1:0] s_axis_tuser_i,
  // Result channel.
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // tdata: vertex_number[8:0], out_x[40:9], out_y[72:41], out_z[104:73],
  // out_tex_u[136:105], out_tex_v[168:137], out_light_u[200:169],
  // out_light_v[232:201], zero pad[239:233].
  output logic [bbpt_pkg::M_TDATA_W-1:0]      m_axis_tdata_o,
  // tuser: kind[0], error[1].
  output logic [bbpt_pkg::M_TUSER_W-1:0]      m_axis_tuser_o,
  output logic                                m_axis_tlast_o
);
  import bbpt_pkg::*;

  // Adds 0.5 in Q16, floors and clamps to the signed 32-bit range.
  function automatic logic signed [CRD_W-1:0] rnd_sat(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] t;
    logic signed [SUM_W-17:0] q;
    logic signed [CRD_W-1:0] r;
    t = s + SUM_W'(32768);
    q = (SUM_W-16)'(t >>> 16);
    if (q > (SUM_W-16)'(64'sh7FFFFFFF)) begin
      r = 32'sh7FFFFFFF;
    end else if (q < -(SUM_W-16)'(64'sh80000000)) begin
      r = 32'sh80000000;
    end else begin
      r = q[CRD_W-1:0];
    end
    return r;
  endfunction

  // Quadratic Bernstein weights from the Q16 parameter a.
  function automatic logic [3*WGT_W-1:0] bern(input logic [WGT_W-1:0] a);
    logic [WGT_W-1:0] b;
    logic [33:0] bb;
    logic [33:0] ab2;
    logic [33:0] aa;
    b   = WGT_W'(17'h10000 - a);
    bb  = 34'(b) * 34'(b) + 34'd32768;
    ab2 = ((34'(a) * 34'(b)) << 1) + 34'd32768;
    aa  = 34'(a) * 34'(a) + 34'd32768;
    return {aa[32:16], ab2[32:16], bb[32:16]};
  endfunction

  // Level register; a level of zero acts as one and larger ones saturate.
  logic [LEVEL_W-1:0] lvl_q;
  logic [LEVEL_W-1:0] lvl_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= LEVEL_RESET;
    end else if (cfg_we_i) begin
      lvl_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (lvl_q == '0) begin
      lvl_eff = LEVEL_W'(1);
    end else if (lvl_q > LEVEL_W'(MAX_LEVEL)) begin
      lvl_eff = LEVEL_W'(MAX_LEVEL);
    end else begin
      lvl_eff = lvl_q;
    end
  end

  // The whole pipeline moves together. It advances whenever the output
  // register is empty or is handing over the last result of its request.
  logic       adv;
  logic       last_now;
  logic [2:0] idx_q;

  // Request unpacking.
  op_e               in_op;
  logic [SLOT_W-1:0] in_slot;
  logic [GRID_W-1:0] in_row;
  logic [GRID_W-1:0] in_col;
  logic [CRD_W-1:0]  in_pt [NUM_CRD];
  meta_t             in_meta;
  logic [9:0]        in_rw;

  always_comb begin
    in_op   = op_e'(s_axis_tuser_i);
    in_slot = s_axis_tdata_i[3:0];
    in_row  = s_axis_tdata_i[8:4];
    in_col  = s_axis_tdata_i[13:9];
    for (int c = 0; c < NUM_CRD; c++) begin
      in_pt[c] = s_axis_tdata_i[14 + c*CRD_W +: CRD_W];
    end
    in_rw         = 10'(in_row) * (10'(lvl_eff) + 10'd1);
    in_meta.op    = in_op;
    in_meta.width = lvl_eff + LEVEL_W'(1);
    in_meta.base  = VNUM_W'(in_rw + 10'(in_col));
    // Sample indices may reach the level, cell indices must stay below it.
    if (in_op == OP_TRI) begin
      in_meta.err = (in_row >= lvl_eff) || (in_col >= lvl_eff);
    end else begin
      in_meta.err = (in_row > lvl_eff) || (in_col > lvl_eff);
    end
  end

  // Stage 1: dividend row*65536 + level/2 and the reciprocal of the level.
  logic              s1_vld_q;
  meta_t             s1_meta_q;
  logic [SLOT_W-1:0] s1_slot_q;
  logic [CRD_W-1:0]  s1_pt_q [NUM_CRD];
  logic [NUM_W-1:0]  s1_numr_q;
  logic [NUM_W-1:0]  s1_numc_q;
  logic [RECIP_W-1:0] s1_recip_q;

  // Stage 2: Q16 parameters.
  logic              s2_vld_q;
  meta_t             s2_meta_q;
  logic [SLOT_W-1:0] s2_slot_q;
  logic [CRD_W-1:0]  s2_pt_q [NUM_CRD];
  logic [WGT_W-1:0]  s2_ar_q;
  logic [WGT_W-1:0]  s2_ac_q;
  logic [NUM_W+RECIP_W-1:0] mr;
  logic [NUM_W+RECIP_W-1:0] mc;

  // Stage 3: weights; loads write the grid here, evaluations read it here.
  logic              s3_vld_q;
  meta_t             s3_meta_q;
  logic [SLOT_W-1:0] s3_slot_q;
  logic [CRD_W-1:0]  s3_pt_q [NUM_CRD];
  logic [WGT_W-1:0]  s3_wr_q [3];
  logic [WGT_W-1:0]  s3_wc_q [3];

  // Stage 4: row products.
  logic              s4_vld_q;
  meta_t             s4_meta_q;
  logic [WGT_W-1:0]  s4_wc_q [3];
  logic signed [PROD_W-1:0] s4_prod_q [3][3][NUM_CRD];

  // Stage 5: rounded row blends.
  logic              s5_vld_q;
  meta_t             s5_meta_q;
  logic [WGT_W-1:0]  s5_wc_q [3];
  logic signed [CRD_W-1:0] s5_tmp_q [3][NUM_CRD];

  // Stage 6: column products.
  logic              s6_vld_q;
  meta_t             s6_meta_q;
  logic signed [PROD_W-1:0] s6_prod_q [3][NUM_CRD];

  // Stage 7: output register.
  logic              s7_vld_q;
  meta_t             s7_meta_q;
  logic signed [CRD_W-1:0] s7_res_q [NUM_CRD];

  // Control grid, nine points of seven coordinates, each read at its own place.
  logic [CRD_W-1:0] grid_q [NUM_PTS][NUM_CRD];

  logic [3*WGT_W-1:0] bern_r;
  logic [3*WGT_W-1:0] bern_c;

  assign mr     = s1_numr_q * s1_recip_q;
  assign mc     = s1_numc_q * s1_recip_q;
  assign bern_r = bern(s2_ar_q);
  assign bern_c = bern(s2_ac_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
    end else if (adv) begin
      // Unused op codes are dropped at the door, loads after the grid write.
      s1_vld_q <= s_axis_tvalid_i && (in_op != OP_NONE);
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q && (s3_meta_q.op != OP_LOAD);
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_meta_q  <= in_meta;
      s1_slot_q  <= in_slot;
      s1_pt_q    <= in_pt;
      s1_numr_q  <= {in_row, 16'd0} + NUM_W'(lvl_eff[LEVEL_W-1:1]);
      s1_numc_q  <= {in_col, 16'd0} + NUM_W'(lvl_eff[LEVEL_W-1:1]);
      s1_recip_q <= recip(lvl_eff);

      s2_meta_q <= s1_meta_q;
      s2_slot_q <= s1_slot_q;
      s2_pt_q   <= s1_pt_q;
      s2_ar_q   <= mr[RECIP_SHIFT +: WGT_W];
      s2_ac_q   <= mc[RECIP_SHIFT +: WGT_W];

      s3_meta_q <= s2_meta_q;
      s3_slot_q <= s2_slot_q;
      s3_pt_q   <= s2_pt_q;
      for (int k = 0; k < 3; k++) begin
        s3_wr_q[k] <= bern_r[k*WGT_W +: WGT_W];
        s3_wc_q[k] <= bern_c[k*WGT_W +: WGT_W];
      end

      s4_meta_q <= s3_meta_q;
      s4_wc_q   <= s3_wc_q;
      for (int j = 0; j < 3; j++) begin
        for (int p = 0; p < 3; p++) begin
          for (int c = 0; c < NUM_CRD; c++) begin
            s4_prod_q[j][p][c] <= PROD_W'($signed(grid_q[j*3+p][c])
                                          * $signed({1'b0, s3_wr_q[p]}));
          end
        end
      end

      s5_meta_q <= s4_meta_q;
      s5_wc_q   <= s4_wc_q;
      for (int j = 0; j < 3; j++) begin
        for (int c = 0; c < NUM_CRD; c++) begin
          s5_tmp_q[j][c] <= rnd_sat(SUM_W'(s4_prod_q[j][0][c])
                                    + SUM_W'(s4_prod_q[j][1][c])
                                    + SUM_W'(s4_prod_q[j][2][c]));
        end
      end

      s6_meta_q <= s5_meta_q;
      for (int j = 0; j < 3; j++) begin
        for (int c = 0; c < NUM_CRD; c++) begin
          s6_prod_q[j][c] <= PROD_W'(s5_tmp_q[j][c] * $signed({1'b0, s5_wc_q[j]}));
        end
      end

      s7_meta_q <= s6_meta_q;
      for (int c = 0; c < NUM_CRD; c++) begin
        s7_res_q[c] <= rnd_sat(SUM_W'(s6_prod_q[0][c]) + SUM_W'(s6_prod_q[1][c])
                               + SUM_W'(s6_prod_q[2][c]));
      end
    end
  end

  // A load writes when it leaves stage 3, so every evaluation sees exactly
  // the loads that were accepted ahead of it. Slots above eight are ignored.
  always_ff @(posedge clk_i) begin
    if (adv && s3_vld_q && (s3_meta_q.op == OP_LOAD)
        && (s3_slot_q < SLOT_W'(NUM_PTS))) begin
      for (int p = 0; p < NUM_PTS; p++) begin
        if (s3_slot_q == SLOT_W'(p)) begin
          grid_q[p] <= s3_pt_q;
        end
      end
    end
  end

  // An in-range triangulate emits six results from the output register; idx_q counts them.
  assign last_now = (s7_meta_q.op != OP_TRI) || s7_meta_q.err || (idx_q == TRI_LAST);
  assign adv      = !s7_vld_q || (m_axis_tready_i && last_now);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (s7_vld_q && m_axis_tready_i) begin
      idx_q <= last_now ? 3'd0 : idx_q + 3'd1;
    end
  end

  // Result assembly. Vertex order of the two triangles of a cell is
  // below-left, here, below-right, below-right, here, right.
  logic [VNUM_W-1:0] vnum;
  logic [VNUM_W-1:0] w9;
  logic              show_crd;

  always_comb begin
    w9 = VNUM_W'(s7_meta_q.width);
    if (s7_meta_q.err) begin
      vnum = '0;
    end else if (s7_meta_q.op != OP_TRI) begin
      vnum = s7_meta_q.base;
    end else begin
      case (idx_q)
        3'd0:    vnum = s7_meta_q.base + w9;
        3'd1:    vnum = s7_meta_q.base;
        3'd2:    vnum = s7_meta_q.base + w9 + VNUM_W'(1);
        3'd3:    vnum = s7_meta_q.base + w9 + VNUM_W'(1);
        3'd4:    vnum = s7_meta_q.base;
        3'd5:    vnum = s7_meta_q.base + VNUM_W'(1);
        default: vnum = s7_meta_q.base;
      endcase
    end
    show_crd = (s7_meta_q.op == OP_EVAL) && !s7_meta_q.err;
    m_axis_tdata_o = '0;
    m_axis_tdata_o[VNUM_W-1:0] = vnum;
    for (int c = 0; c < NUM_CRD; c++) begin
      m_axis_tdata_o[VNUM_W + c*CRD_W +: CRD_W] = show_crd ? s7_res_q[c] : '0;
    end
  end

  assign s_axis_tready_o   = adv;
  assign m_axis_tvalid_o   = s7_vld_q;
  assign m_axis_tlast_o    = last_now;
  assign m_axis_tuser_o[0] = (s7_meta_q.op == OP_TRI);
  assign m_axis_tuser_o[1] = s7_meta_q.err;

endmodule

`default_nettype wire

// ===== tb/sv/bbpt_scoreboard.sv =====
// ----------------------------------------------------------------------------
// bbpt_scoreboard
// Watches the level write port and both streams of the patch tessellator.
// It predicts each result and compares it with what the block returns.
// ----------------------------------------------------------------------------
`default_nettype none

module bbpt_scoreboard
  import bbpt_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [LEVEL_W-1:0]     cfg_wdata_i,
  input  wire logic                   s_axis_tvalid_i,
  input  wire logic                   s_axis_tready_i,
  input  wire logic [S_TDATA_W-1:0]   s_axis_tdata_i,
  input  wire logic [S_TUSER_W-1:0]   s_axis_tuser_i,
  input  wire logic                   m_axis_tvalid_i,
  input  wire logic                   m_axis_tready_i,
  input  wire logic [M_TDATA_W-1:0]   m_axis_tdata_i,
  input  wire logic [M_TUSER_W-1:0]   m_axis_tuser_i,
  input  wire logic                   m_axis_tlast_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic              kind;
    logic              err;
    logic [VNUM_W-1:0] vnum;
    logic [CRD_W-1:0]  crd[NUM_CRD];
    logic              last;
  } vertex_t;

  vertex_t             vertex_q[$];
  logic [CRD_W-1:0]    ctrl_pts[NUM_PTS][NUM_CRD];
  logic [LEVEL_W-1:0]  level_reg;

  assign pending_o = vertex_q.size();

  function automatic int unsigned clamp_level(input logic [LEVEL_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_LEVEL) return MAX_LEVEL;
    return raw;
  endfunction

  // Bernstein weights in Q1.16 for parameter n / lvl, rounded half up.
  function automatic void bern_weights(input int unsigned n, input int unsigned lvl,
                                       output longint w[3]);
    longint a;
    longint b;
    a = (longint'(n) * 65536 + lvl / 2) / lvl;
    if (a > 65536) a = 65536;
    b = 65536 - a;
    w[0] = (b * b + 32768) >> 16;
    w[1] = (2 * a * b + 32768) >> 16;
    w[2] = (a * a + 32768) >> 16;
  endfunction

  function automatic longint mix3(input longint c0, input longint c1, input longint c2,
                                  input longint w[3]);
    longint acc;
    acc = c0 * w[0] + c1 * w[1] + c2 * w[2] + 32768;
    acc = acc >>> 16;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc;
  endfunction

  function automatic vertex_t blank_vertex(input logic kind, input logic err,
                                           input logic [VNUM_W-1:0] vnum,
                                           input logic last);
    vertex_t v;
    v.kind = kind;
    v.err  = err;
    v.vnum = vnum;
    v.last = last;
    foreach (v.crd[i]) v.crd[i] = '0;
    return v;
  endfunction

  task automatic predict_request(input logic [S_TDATA_W-1:0] d,
                                 input logic [S_TUSER_W-1:0] u);
    op_e          op;
    int unsigned  slot, row, col, lvl;
    longint       wr[3], wc[3];
    longint       rowmix[3][NUM_CRD];
    vertex_t      v;
    op   = op_e'(u);
    slot = d[3:0];
    row  = d[8:4];
    col  = d[13:9];
    lvl  = clamp_level(level_reg);
    case (op)
      OP_LOAD: begin
        // Slots past the grid are dropped silently.
        if (slot < NUM_PTS)
          for (int i = 0; i < NUM_CRD; i++) ctrl_pts[slot][i] = d[14 + 32*i +: 32];
      end
      OP_EVAL: begin
        if (row > lvl || col > lvl) begin
          vertex_q.push_back(blank_vertex(1'b0, 1'b1, '0, 1'b1));
        end else begin
          bern_weights(row, lvl, wr);
          bern_weights(col, lvl, wc);
          v = blank_vertex(1'b0, 1'b0, VNUM_W'(row * (lvl + 1) + col), 1'b1);
          for (int j = 0; j < 3; j++)
            for (int i = 0; i < NUM_CRD; i++)
              rowmix[j][i] = mix3(longint'($signed(ctrl_pts[3*j][i])),
                                  longint'($signed(ctrl_pts[3*j+1][i])),
                                  longint'($signed(ctrl_pts[3*j+2][i])), wr);
          for (int i = 0; i < NUM_CRD; i++)
            v.crd[i] = CRD_W'(mix3(rowmix[0][i], rowmix[1][i], rowmix[2][i], wc));
          vertex_q.push_back(v);
        end
      end
      OP_TRI: begin
        if (row >= lvl || col >= lvl) begin
          vertex_q.push_back(blank_vertex(1'b1, 1'b1, '0, 1'b1));
        end else begin
          // Two triangles of the cell, in the block's winding order.
          vertex_q.push_back(blank_vertex(1'b1, 1'b0, VNUM_W'((row+1)*(lvl+1)+col), 1'b0));
          vertex_q.push_back(blank_vertex(1'b1, 1'b0, VNUM_W'(row*(lvl+1)+col), 1'b0));
          vertex_q.push_back(blank_vertex(1'b1, 1'b0, VNUM_W'((row+1)*(lvl+1)+col+1), 1'b0));
          vertex_q.push_back(blank_vertex(1'b1, 1'b0, VNUM_W'((row+1)*(lvl+1)+col+1), 1'b0));
          vertex_q.push_back(blank_vertex(1'b1, 1'b0, VNUM_W'(row*(lvl+1)+col), 1'b0));
          vertex_q.push_back(blank_vertex(1'b1, 1'b0, VNUM_W'(row*(lvl+1)+col+1), 1'b1));
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input logic [CRD_W-1:0] got,
                        input logic [CRD_W-1:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  task automatic compare_vertex();
    vertex_t     want;
    string       crd_names[NUM_CRD];
    crd_names = '{"x", "y", "z", "tex_u", "tex_v", "light_u", "light_v"};
    if (vertex_q.size() == 0) begin
      report("unexpected result", m_axis_tdata_i[31:0], '0);
      return;
    end
    want = vertex_q.pop_front();
    if (m_axis_tuser_i[0] !== want.kind) report("kind", m_axis_tuser_i[0], want.kind);
    if (m_axis_tuser_i[1] !== want.err) report("error", m_axis_tuser_i[1], want.err);
    if (m_axis_tlast_i !== want.last) report("last", m_axis_tlast_i, want.last);
    if (m_axis_tdata_i[8:0] !== want.vnum)
      report("vertex_number", m_axis_tdata_i[8:0], want.vnum);
    for (int i = 0; i < NUM_CRD; i++)
      if (m_axis_tdata_i[9 + 32*i +: 32] !== want.crd[i])
        report(crd_names[i], m_axis_tdata_i[9 + 32*i +: 32], want.crd[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_reg <= LEVEL_RESET;
      fail_count_o = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) predict_request(s_axis_tdata_i, s_axis_tuser_i);
      if (m_axis_tvalid_i && m_axis_tready_i) compare_vertex();
      if (cfg_we_i) level_reg <= cfg_wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/biquadratic_bezier_patch_tessellator_test.sv =====
// ----------------------------------------------------------------------------
// biquadratic_bezier_patch_tessellator_test
// Loads the control grid, then sends evaluate, triangulate, load and unused
// requests over several tessellation levels with random idling on both
// streams. The scoreboard beside the block predicts and checks every result.
// ----------------------------------------------------------------------------
`default_nettype none

module biquadratic_bezier_patch_tessellator_test;
  import bbpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 30;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [LEVEL_W-1:0]   cfg_wdata_i = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b1;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic [M_TUSER_W-1:0] m_axis_tuser_o;
  logic                 m_axis_tlast_o;

  int fail_count;
  int pending;
  int cycle_count = 0;
  // Once set, neither side idles any more.
  logic calm = 1'b0;
  int   sink_stall = 0;
  // Level as the block applies it, used only to aim the row and column values.
  int unsigned lvl_now = 8;

  always #6 clk_i = ~clk_i;

  biquadratic_bezier_patch_tessellator DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o,
    .m_axis_tlast_o
  );

  bbpt_scoreboard checker_inst (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .m_axis_tuser_i(m_axis_tuser_o), .m_axis_tlast_i(m_axis_tlast_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: stops the run as failed once cycle_count passes CYCLE_LIMIT.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // The result side stalls in random bursts, unless the run has gone calm.
  always @(posedge clk_i) begin
    if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      m_axis_tready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      sink_stall <= $urandom_range(0, 13);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Coordinates lean toward the extremes now and then to exercise saturation.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  // Drives one request and holds it until the block takes it.
  task automatic send_request(input op_e op, input int unsigned slot,
                              input int unsigned row, input int unsigned col,
                              input logic [31:0] crd[NUM_CRD]);
    logic took;
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= {2'b00, crd[6], crd[5], crd[4], crd[3], crd[2], crd[1], crd[0],
                       5'(col), 5'(row), 4'(slot)};
    do begin
      @(negedge clk_i);
      took = s_axis_tready_o;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic load_point(input int unsigned slot);
    logic [31:0] crd[NUM_CRD];
    foreach (crd[i]) crd[i] = pick_coord();
    send_request(OP_LOAD, slot, $urandom_range(0, 31), $urandom_range(0, 31), crd);
  endtask

  task automatic grid_request(input op_e op, input int unsigned row, input int unsigned col);
    logic [31:0] crd[NUM_CRD];
    foreach (crd[i]) crd[i] = $urandom;
    send_request(op, $urandom_range(0, 15), row, col, crd);
  endtask

  // The level may only change while nothing is in flight. A load gives no
  // result, so the pipeline is left to drain for a while as well.
  task automatic write_level(input logic [LEVEL_W-1:0] value);
    s_axis_tvalid_i <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lvl_now = (value == 0) ? 1 : (value > MAX_LEVEL) ? MAX_LEVEL : value;
  endtask

  task automatic random_phase(input int count);
    int unsigned pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) load_point($urandom_range(0, 8));
      else if (pick < 14) load_point($urandom_range(9, 15));
      else if (pick < 16) grid_request(OP_NONE, $urandom_range(0, 31), $urandom_range(0, 31));
      else if (pick < 56) begin
        // Mostly in range, with a few just past the edge or far beyond it.
        if ($urandom_range(0, 9) == 0)
          grid_request(OP_EVAL, $urandom_range(0, 31), $urandom_range(0, 31));
        else
          grid_request(OP_EVAL, $urandom_range(0, lvl_now), $urandom_range(0, lvl_now));
      end else begin
        if ($urandom_range(0, 9) == 0)
          grid_request(OP_TRI, $urandom_range(0, 31), $urandom_range(0, 31));
        else
          grid_request(OP_TRI, $urandom_range(0, lvl_now - 1), $urandom_range(0, lvl_now - 1));
      end
    end
  endtask

  initial begin
    logic [31:0] crd[NUM_CRD];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: fill every slot first, since the grid has no reset value.
    foreach (crd[i]) crd[i] = 32'h7fff_ffff;
    send_request(OP_LOAD, 0, 0, 0, crd);
    foreach (crd[i]) crd[i] = 32'h8000_0000;
    send_request(OP_LOAD, 8, 31, 31, crd);
    for (int s = 1; s < 8; s++) load_point(s);
    foreach (crd[i]) crd[i] = 32'hffff_ffff;
    send_request(OP_LOAD, 15, 0, 0, crd);          // out-of-grid slot is dropped
    grid_request(OP_EVAL, 0, 0);
    grid_request(OP_EVAL, 8, 8);
    grid_request(OP_EVAL, 4, 3);
    grid_request(OP_EVAL, 9, 0);                  // just past the level
    grid_request(OP_EVAL, 0, 31);
    grid_request(OP_TRI, 0, 0);
    grid_request(OP_TRI, 7, 7);
    grid_request(OP_TRI, 8, 0);                   // cell row must stay below the level
    grid_request(OP_TRI, 3, 31);
    grid_request(OP_NONE, 2, 2);                  // unused op is ignored

    random_phase(35);
    write_level(5'd1);
    grid_request(OP_EVAL, 1, 1);
    grid_request(OP_TRI, 0, 0);
    random_phase(35);
    write_level(5'd16);
    grid_request(OP_EVAL, 16, 16);
    grid_request(OP_TRI, 15, 15);
    random_phase(40);
    write_level(5'd0);                            // acts as a level of one
    random_phase(25);
    write_level(5'd31);                           // clamps to the maximum level
    random_phase(30);
    write_level(5'd3);
    random_phase(40);
    write_level(5'($urandom_range(2, 15)));
    random_phase(50);
    calm = 1'b1;
    random_phase(40);
    s_axis_tvalid_i <= 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/bbpt_pkg.sv
src/biquadratic_bezier_patch_tessellator.sv
tb/sv/bbpt_scoreboard.sv
tb/sv/biquadratic_bezier_patch_tessellator_test.sv
